// File: src/yaz0d_pkg.sv
package yaz0d_pkg;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_CODE    = 2'd0;
  localparam logic [1:0] KIND_TAKE    = 2'd1;
  localparam logic [1:0] KIND_SKIP    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ACCEPT  = 3'd0;
  localparam logic [2:0] ST_DELIVER = 3'd1;
  localparam logic [2:0] ST_SKIP    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_REFUSE  = 3'd4;
  localparam logic [2:0] ST_RESTART = 3'd5;

  // Token constants of the compressed format
  localparam logic [8:0] SHORT_LEN_BIAS = 9'h002;
  localparam logic [8:0] LONG_LEN_BIAS  = 9'h012;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
  } req_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

// File: src/yaz0d_ram.sv
module yaz0d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/yaz0d_front.sv
module yaz0d_front
  import yaz0d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_code_byte,
  input  logic       busy,
  input  logic       pop,
  output head_t      head
);

  req_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              do_pop;
  req_t              req_in;

  // Refuse requests while full or while the window is being cleared
  assign in_stall = (count_r == (QPTR_W+1)'(QUEUE_DEPTH)) || busy;
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  // Classify the request: only code requests carry a byte
  always_comb begin
    req_in.kind = in_kind;
    req_in.code = (in_kind == KIND_CODE) ? in_code_byte : 8'h00;
  end

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= req_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head.valid = (count_r != '0);
  assign head.req   = q_r[rd_ptr_r];

endmodule

// File: src/yaz0d_back.sv
module yaz0d_back
  import yaz0d_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  head_t      head,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic [8:0] out_bytes_pending
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_LENGTH = 2'd3;

  // Clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Decoder state
  logic [AW-1:0] wp_r, wp_nxt;
  logic [8:0]    pend_r, pend_nxt;
  logic [11:0]   dist_r, dist_nxt;
  logic          copy_r, copy_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [2:0]    used_r, used_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    first_r, first_nxt;

  // Issue-side decisions
  logic          a_finish;
  logic          a_rd;
  logic          a_wr;
  logic          a_lit;
  logic [AW-1:0] a_raddr;
  logic [2:0]    a_status;
  logic [AW:0]   src_ext;
  logic [AW-1:0] src;

  // Output stage
  logic          b_valid_r;
  logic [2:0]    b_status_r;
  logic [8:0]    b_pend_r;
  logic          b_wr_r;
  logic          b_lit_r;
  logic [7:0]    b_code_r;
  logic [AW-1:0] b_waddr_r;
  logic          b_fwd_r;
  logic [7:0]    b_fwd_val_r;

  logic          adv;
  logic          b_leave;
  logic          b_wr_now;
  logic [7:0]    vb;
  logic [7:0]    b_wdata;
  logic [7:0]    ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign busy     = clr_busy_r;
  assign adv      = !b_valid_r || !out_stall;
  assign pop      = adv && head.valid && !clr_busy_r;
  assign b_leave  = b_valid_r && !out_stall;
  assign b_wr_now = b_leave && b_wr_r;

  // Copy source: one behind the write position, then back by the distance
  always_comb begin
    src_ext = {1'b0, wp_r} - (AW+1)'(1) - (AW+1)'(dist_r);
    if (src_ext[AW]) begin
      src_ext = src_ext + (AW+1)'(WINDOW_DEPTH);
    end
    src = src_ext[AW-1:0];
  end

  // Decode the request at the queue head
  always_comb begin
    wp_nxt    = wp_r;
    pend_nxt  = pend_r;
    dist_nxt  = dist_r;
    copy_nxt  = copy_r;
    flag_nxt  = flag_r;
    used_nxt  = used_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    a_finish  = 1'b0;
    a_rd      = 1'b0;
    a_wr      = 1'b0;
    a_lit     = 1'b0;
    a_raddr   = wp_r;
    a_status  = ST_ACCEPT;

    unique case (head.req.kind)
      KIND_CODE: begin
        if (pend_r != '0) begin
          a_status = ST_REFUSE;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              flag_nxt  = head.req.code;
              used_nxt  = 3'd0;
              phase_nxt = PH_TOKEN;
            end
            PH_TOKEN: begin
              if (flag_r[7]) begin
                // literal goes straight into the window
                a_wr     = 1'b1;
                a_lit    = 1'b1;
                copy_nxt = 1'b0;
                pend_nxt = 9'd1;
                a_finish = 1'b1;
              end else begin
                first_nxt = head.req.code;
                phase_nxt = PH_SECOND;
              end
            end
            PH_SECOND: begin
              dist_nxt = {first_r[3:0], head.req.code};
              if (first_r[7:4] != 4'h0) begin
                pend_nxt = 9'(first_r[7:4]) + SHORT_LEN_BIAS;
                copy_nxt = 1'b1;
                a_finish = 1'b1;
              end else begin
                phase_nxt = PH_LENGTH;
              end
            end
            default: begin
              pend_nxt = 9'(head.req.code) + LONG_LEN_BIAS;
              copy_nxt = 1'b1;
              a_finish = 1'b1;
            end
          endcase
        end
      end
      KIND_RESTART: begin
        wp_nxt    = '0;
        pend_nxt  = '0;
        dist_nxt  = '0;
        copy_nxt  = 1'b0;
        flag_nxt  = '0;
        used_nxt  = 3'd7;
        phase_nxt = PH_HEADER;
        first_nxt = '0;
        a_status  = ST_RESTART;
      end
      default: begin
        if (pend_r == '0) begin
          a_status = ST_EMPTY;
        end else begin
          // produce one byte: read source now, write it back next stage
          a_rd     = 1'b1;
          a_wr     = 1'b1;
          a_raddr  = copy_r ? src : wp_r;
          wp_nxt   = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
          pend_nxt = pend_r - 9'd1;
          if (pend_nxt == '0) begin
            copy_nxt = 1'b0;
          end
          a_status = (head.req.kind == KIND_TAKE) ? ST_DELIVER : ST_SKIP;
        end
      end
    endcase

    // Close a token: shift flags, open a new group after the eighth
    if (a_finish) begin
      flag_nxt = {flag_r[6:0], 1'b0};
      if (used_r == 3'd7) begin
        phase_nxt = PH_HEADER;
      end else begin
        used_nxt  = used_r + 3'd1;
        phase_nxt = PH_TOKEN;
      end
    end
  end

  // Commit decoder state on each popped request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      pend_r  <= '0;
      dist_r  <= '0;
      copy_r  <= 1'b0;
      flag_r  <= '0;
      used_r  <= 3'd7;
      phase_r <= PH_HEADER;
      first_r <= '0;
    end else if (pop) begin
      wp_r    <= wp_nxt;
      pend_r  <= pend_nxt;
      dist_r  <= dist_nxt;
      copy_r  <= copy_nxt;
      flag_r  <= flag_nxt;
      used_r  <= used_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
    end
  end

  // Sweep the window to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(WINDOW_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Output stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= pop;
    end
  end

  // Output stage payload; forward a byte written on the same edge as the read
  always_ff @(posedge clk) begin
    if (pop) begin
      b_status_r  <= a_status;
      b_pend_r    <= pend_nxt;
      b_wr_r      <= a_wr;
      b_lit_r     <= a_lit;
      b_code_r    <= head.req.code;
      b_waddr_r   <= wp_r;
      b_fwd_r     <= a_rd && b_wr_now && (b_waddr_r == a_raddr);
      b_fwd_val_r <= b_wdata;
    end
  end

  assign vb      = b_fwd_r ? b_fwd_val_r : ram_rdata;
  assign b_wdata = b_lit_r ? b_code_r : vb;

  // Single write port: clearing pass or the leaving output stage
  assign ram_we    = clr_busy_r || b_wr_now;
  assign ram_waddr = clr_busy_r ? clr_addr_r : b_waddr_r;
  assign ram_wdata = clr_busy_r ? 8'h00 : b_wdata;

  yaz0d_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop && a_rd),
    .raddr (a_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = b_valid_r;
  assign out_byte          = (b_status_r == ST_DELIVER) ? vb : 8'h00;
  assign out_status        = b_status_r;
  assign out_bytes_pending = b_pend_r;

endmodule

// File: src/yaz0_stream_decompressor.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_kind, in_code_byte
// result    out_valid / out_stall  out_byte, out_status, out_bytes_pending
//
// One request enters per cycle while in_stall is low. A request leaves the queue
// at the earliest the cycle after it is taken, and its result is presented right
// after that edge; a stalled result delays both (queue, then decode with window
// read into the output stage).
// The window memory has one write and one read port; a byte written back as
// its result leaves is forwarded to a read on the same edge.
// After reset a clearing pass writes WINDOW_DEPTH zero bytes, one per cycle;
// in_stall stays high meanwhile. A stalled result holds the back part, while
// the four-entry request queue keeps taking requests until full.
module yaz0_stream_decompressor
  import yaz0d_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_code_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic [8:0] out_bytes_pending
);

  head_t head;
  logic  pop;
  logic  busy;

  yaz0d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_code_byte (in_code_byte),
    .busy         (busy),
    .pop          (pop),
    .head         (head)
  );

  yaz0d_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_status        (out_status),
    .out_bytes_pending (out_bytes_pending)
  );

endmodule
